FILE: hw/rtl/sbfd_pkg.sv
// Shared constants and types of the SBUS frame decoder with link watchdog.
package sbfd_pkg;

    localparam int FRAME_LEN    = 25;
    localparam int STORE_LEN    = FRAME_LEN - 1;
    localparam int COUNT_W      = 5;
    localparam int BYTE_W       = 8;
    localparam int CH_W         = 11;
    localparam int STICK_W      = 12;
    localparam int NUM_CH       = 10;
    localparam int NUM_STICKS   = 6;
    localparam int NUM_SWITCHES = 4;
    localparam int ACTIVE_CHANS = 5;
    localparam int ONLINE_W     = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [BYTE_W-1:0]   SYNC_HEAD      = 8'h0F;
    localparam logic [BYTE_W-1:0]   SYNC_TAIL      = 8'h00;
    localparam logic [ONLINE_W-1:0] LINK_RELOAD    = 8'hFA;
    localparam logic [ONLINE_W-1:0] LINK_FLOOR     = 8'h32;
    localparam logic [CH_W-1:0]     OFFSET_RESET   = 11'd1024;
    localparam logic [CH_W-1:0]     DEADZONE_RESET = 11'd10;

    // Input word kinds.
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CH0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CH1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CH2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CH3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CH4 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CH5 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE   = 3'd6;

    typedef enum logic {
        CMD_FRAME,
        CMD_TICK
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                      kind;
        logic [NUM_CH-1:0][CH_W-1:0]    raw;
    } t_cmd;

endpackage

FILE: hw/rtl/sbfd_if.sv
// Valid/ready channel interfaces of the input, result and configuration ports.
interface sbfd_in_if;
    import sbfd_pkg::*;
    logic              valid;
    logic              ready;
    logic              action;
    logic [BYTE_W-1:0] rx_byte;
    logic              block_start;
    modport source (output valid, output action, output rx_byte, output block_start,
                    input ready);
    modport sink   (input valid, input action, input rx_byte, input block_start,
                    output ready);
endinterface

interface sbfd_out_if;
    import sbfd_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [STICK_W-1:0] stick0;
    logic signed [STICK_W-1:0] stick1;
    logic signed [STICK_W-1:0] stick2;
    logic signed [STICK_W-1:0] stick3;
    logic signed [STICK_W-1:0] stick4;
    logic signed [STICK_W-1:0] stick5;
    logic [CH_W-1:0]           switch0;
    logic [CH_W-1:0]           switch1;
    logic [CH_W-1:0]           switch2;
    logic [CH_W-1:0]           switch3;
    logic [ACTIVE_CHANS-1:0]   active_mask;
    logic                      link_lost;
    modport source (output valid, output stick0, output stick1, output stick2,
                    output stick3, output stick4, output stick5, output switch0,
                    output switch1, output switch2, output switch3,
                    output active_mask, output link_lost, input ready);
    modport sink   (input valid, input stick0, input stick1, input stick2,
                    input stick3, input stick4, input stick5, input switch0,
                    input switch1, input switch2, input switch3,
                    input active_mask, input link_lost, output ready);
endinterface

interface sbfd_cfg_if;
    import sbfd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CH_W-1:0]      data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/sbfd_front.sv
// Front end: assembles the 25-byte frame, checks it and queues frames and ticks.
module sbfd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sbfd_in_if.sink       i_in,
    input  logic          i_q_full,
    output logic          o_push,
    output sbfd_pkg::t_cmd o_cmd
);
    import sbfd_pkg::*;

    logic [BYTE_W-1:0]          r_frame [STORE_LEN];
    logic [COUNT_W-1:0]         r_count;
    logic [COUNT_W-1:0]         n_count;
    logic [COUNT_W-1:0]         w_idx;
    logic                       w_take;
    logic [8*(STORE_LEN-1)-1:0] w_bits;

    assign i_in.ready = !i_q_full;
    assign w_take     = i_in.valid && i_in.ready;
    assign w_idx      = i_in.block_start ? '0 : r_count;

    // Channel bits start right after the header byte, least significant bit first.
    always_comb begin
        for (int k = 0; k < STORE_LEN - 1; k++) begin
            w_bits[8*k +: 8] = r_frame[k + 1];
        end
    end

    always_comb begin
        n_count    = r_count;
        o_push     = 1'b0;
        o_cmd.kind = CMD_FRAME;
        for (int i = 0; i < NUM_CH; i++) begin
            o_cmd.raw[i] = w_bits[CH_W*i +: CH_W];
        end
        if (w_take) begin
            if (i_in.action == ACT_TICK) begin
                o_push     = 1'b1;
                o_cmd.kind = CMD_TICK;
            end else if (w_idx < COUNT_W'(FRAME_LEN)) begin
                n_count = w_idx + 1'b1;
                if (w_idx == COUNT_W'(FRAME_LEN - 1) && r_frame[0] == SYNC_HEAD &&
                    i_in.rx_byte == SYNC_TAIL) begin
                    o_push = 1'b1;
                end
            end
        end
    end

    // The last byte is only the footer, so it is checked on the fly and never stored.
    always_ff @(posedge i_clk) begin
        if (w_take && i_in.action == ACT_BYTE && w_idx < COUNT_W'(STORE_LEN)) begin
            r_frame[w_idx] <= i_in.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_W'(FRAME_LEN);
        end else begin
            r_count <= n_count;
        end
    end

endmodule

FILE: hw/rtl/sbfd_queue.sv
// Short command queue between the front end and the back end.
module sbfd_queue #(
    parameter int DEPTH = sbfd_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sbfd_pkg::t_cmd i_data,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output sbfd_pkg::t_cmd o_data
);
    import sbfd_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic [PW-1:0]   n_wr;
    logic [PW-1:0]   n_rd;
    logic [CW-1:0]   n_cnt;

    assign o_valid = r_cnt != '0;
    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: hw/rtl/sbfd_back.sv
// Back end: channel state, offsets, link watchdog and the result register.
module sbfd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  sbfd_pkg::t_cmd i_cmd,
    output logic           o_pop,
    sbfd_cfg_if.sink       i_cfg,
    sbfd_out_if.source     o_out
);
    import sbfd_pkg::*;

    // The channel registers are the decoder state and also the result payload,
    // since they change only on commands that produce a result.
    logic [STICK_W-1:0]  r_stick  [NUM_STICKS];
    logic [STICK_W-1:0]  n_stick  [NUM_STICKS];
    logic [CH_W-1:0]     r_switch [NUM_SWITCHES];
    logic [CH_W-1:0]     n_switch [NUM_SWITCHES];
    logic [ONLINE_W-1:0] r_online;
    logic [ONLINE_W-1:0] n_online;
    logic                r_lost;
    logic                n_lost;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [CH_W-1:0]     r_offset [NUM_STICKS];
    logic [CH_W-1:0]     r_deadzone;
    logic                w_cfg_wr;
    logic [STICK_W-1:0]  w_mag [ACTIVE_CHANS];
    logic [ACTIVE_CHANS-1:0] w_mask;

    assign o_pop       = i_cmd_valid && (!r_out_valid || o_out.ready);
    assign i_cfg.ready = 1'b1;
    assign w_cfg_wr    = i_cfg.valid && i_cfg.ready;

    always_comb begin
        n_stick     = r_stick;
        n_switch    = r_switch;
        n_online    = r_online;
        n_lost      = r_lost;
        n_out_valid = r_out_valid;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (o_pop) begin
            n_out_valid = 1'b1;
            case (i_cmd.kind)
                CMD_TICK: begin
                    if (r_online <= LINK_FLOOR) begin
                        for (int i = 0; i < NUM_STICKS; i++) begin
                            n_stick[i] = '0;
                        end
                        for (int i = 0; i < NUM_SWITCHES; i++) begin
                            n_switch[i] = '0;
                        end
                        n_online = '0;
                        n_lost   = 1'b1;
                    end else begin
                        n_online = r_online - 1'b1;
                    end
                end
                CMD_FRAME: begin
                    for (int i = 0; i < NUM_STICKS; i++) begin
                        n_stick[i] = {1'b0, i_cmd.raw[i]} - {1'b0, r_offset[i]};
                    end
                    for (int i = 0; i < NUM_SWITCHES; i++) begin
                        n_switch[i] = i_cmd.raw[NUM_STICKS + i];
                    end
                    n_online = LINK_RELOAD;
                    n_lost   = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // The user must change the deadzone only while no result is pending (the block
    // itself does not enforce it), so the mask can be formed from the result register.
    always_comb begin
        for (int i = 0; i < ACTIVE_CHANS; i++) begin
            w_mag[i]  = r_stick[i][STICK_W-1] ? (STICK_W'(0) - r_stick[i]) : r_stick[i];
            w_mask[i] = w_mag[i] >= {1'b0, r_deadzone};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_STICKS; i++) begin
                r_stick[i]  <= '0;
                r_offset[i] <= OFFSET_RESET;
            end
            for (int i = 0; i < NUM_SWITCHES; i++) begin
                r_switch[i] <= '0;
            end
            r_online    <= LINK_RELOAD;
            r_lost      <= 1'b1;
            r_out_valid <= 1'b0;
            r_deadzone  <= DEADZONE_RESET;
        end else begin
            r_stick     <= n_stick;
            r_switch    <= n_switch;
            r_online    <= n_online;
            r_lost      <= n_lost;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr) begin
                case (i_cfg.index)
                    REG_OFFSET_CH0, REG_OFFSET_CH1, REG_OFFSET_CH2,
                    REG_OFFSET_CH3, REG_OFFSET_CH4, REG_OFFSET_CH5: begin
                        r_offset[i_cfg.index] <= i_cfg.data;
                    end
                    REG_DEADZONE: begin
                        r_deadzone <= i_cfg.data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.stick0      = $signed(r_stick[0]);
    assign o_out.stick1      = $signed(r_stick[1]);
    assign o_out.stick2      = $signed(r_stick[2]);
    assign o_out.stick3      = $signed(r_stick[3]);
    assign o_out.stick4      = $signed(r_stick[4]);
    assign o_out.stick5      = $signed(r_stick[5]);
    assign o_out.switch0     = r_switch[0];
    assign o_out.switch1     = r_switch[1];
    assign o_out.switch2     = r_switch[2];
    assign o_out.switch3     = r_switch[3];
    assign o_out.active_mask = w_mask;
    assign o_out.link_lost   = r_lost;

endmodule

FILE: hw/rtl/sbus_frame_decoder_with_link_watchdog_top.sv
// Top level of the SBUS frame decoder with link watchdog.
// The block takes one input word per clock: a received byte or a watchdog tick.
// The front end stores bytes, checks the header and footer on the 25th byte and
// hands each valid frame or tick as a command to a queue of QUEUE_DEPTH entries;
// input ready drops only while that queue is full. The back end takes one command
// per cycle into the result register whenever that register is empty or being
// read. Each command is registered in the queue and then in the result register,
// so the sustained rate is one word per cycle while results are read. Bytes that do
// not complete a valid frame give no result. Configuration writes are taken in any
// cycle (ready is always high) and must be made while no result is pending.
module sbus_frame_decoder_with_link_watchdog_top #(
    parameter int QUEUE_DEPTH = sbfd_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sbfd_in_if.sink    i_in,
    sbfd_cfg_if.sink   i_cfg,
    sbfd_out_if.source o_out
);
    import sbfd_pkg::*;

    logic w_push;
    logic w_pop;
    logic w_q_valid;
    logic w_q_full;
    t_cmd w_push_cmd;
    t_cmd w_head_cmd;

    sbfd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    sbfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_data  (w_head_cmd)
    );

    sbfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_head_cmd),
        .o_pop       (w_pop),
        .i_cfg       (i_cfg),
        .o_out       (o_out)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_full |-> !w_push)
        else $error("command pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("command popped from an empty queue");

    a_lost_clears_channels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.link_lost |-> (o_out.stick0 == 0 && o_out.stick3 == 0 &&
                             o_out.switch0 == 0 && o_out.switch3 == 0))
        else $error("link lost while channels still hold values");

endmodule
